// ===== sv/tcon_pkg.sv =====
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared types, constants and helpers for the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcon_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [COL_W-1:0]  TAB_STEP   = 7'd8;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [3:0]  bg_colour;
        logic [3:0]  fg_colour;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [10:0]       cursor_location;
        logic [CELL_W-1:0] cell_word;
        logic              scrolled;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } ram_wr_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcon_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcon_screen_ram
// Screen store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_screen_ram (
    input  wire logic                            clk,
    input  wire tcon_pkg::ram_wr_t               wr,
    input  wire logic                            rd_en,
    input  wire logic [tcon_pkg::ADDR_W-1:0]     rd_addr,
    output logic      [tcon_pkg::CELL_W-1:0]     rd_data
);

    logic [tcon_pkg::CELL_W-1:0] mem [0:tcon_pkg::CELLS-1];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// 80x25 text console: screen store, cursor, scroll and clear sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  command  | start / busy     | cmd    (tcon_pkg::cmd_t)
//  result   | done (strobe)    | result (tcon_pkg::result_t)
//
//  Put, read and unused actions pass the execute and done states, then the
//  done strobe; a new command can be taken in the cycle that shows the result.
//  A put that scrolls adds a scroll pass: one store cell copied, or blanked
//  for the last row, per cycle over the single write port. Clear adds a
//  sweep, one cell blanked per cycle; reset blanks the store with busy high.
//  The receiver cannot stall: each result beat is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire tcon_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output tcon_pkg::result_t      result
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_SCROLL,
        ST_DONE
    } state_t;

    localparam logic [tcon_pkg::ADDR_W-1:0] LAST_CELL  = tcon_pkg::ADDR_W'(tcon_pkg::CELLS - 1);
    localparam logic [tcon_pkg::ADDR_W-1:0] END_SCROLL = tcon_pkg::ADDR_W'(tcon_pkg::CELLS);
    localparam logic [tcon_pkg::ADDR_W-1:0] COPY_CELLS =
        tcon_pkg::ADDR_W'(tcon_pkg::CELLS - tcon_pkg::COLUMNS);

    state_t                        state_reg;
    logic [tcon_pkg::ADDR_W-1:0]   cnt_reg;
    logic [tcon_pkg::COL_W-1:0]    col_reg;
    logic [tcon_pkg::ROW_W-1:0]    row_reg;
    tcon_pkg::cmd_t                req_reg;
    logic                          scrolled_reg;
    logic                          word_ok_reg;
    logic                          done_reg;
    tcon_pkg::result_t             result_reg;

    logic [tcon_pkg::COL_W-1:0]    col_put;
    logic [tcon_pkg::ROW_W-1:0]    row_put;
    logic                          printable;
    logic                          put_scroll;
    logic [tcon_pkg::ADDR_W-1:0]   put_pos;
    logic                          index_ok;
    logic [tcon_pkg::ADDR_W-1:0]   cnt_m1;

    tcon_pkg::ram_wr_t             ram_wr;
    logic                          ram_rd_en;
    logic [tcon_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [tcon_pkg::CELL_W-1:0]   ram_rd_data;

    tcon_screen_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign printable = req_reg.char_code inside {[tcon_pkg::CH_SPACE:tcon_pkg::CH_DEL]};
    assign put_pos   = tcon_pkg::cell_addr(row_reg, col_reg);
    assign index_ok  = req_reg.cell_index < tcon_pkg::ADDR_W'(tcon_pkg::CELLS);
    assign cnt_m1    = cnt_reg - tcon_pkg::ADDR_W'(1);

    always_comb
    begin
        col_put = col_reg;
        row_put = row_reg;
        case (req_reg.char_code)
            tcon_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_put = col_reg - tcon_pkg::COL_W'(1);
                end
            end
            tcon_pkg::CH_TAB:
            begin
                col_put = (col_reg + tcon_pkg::TAB_STEP)
                          & ~(tcon_pkg::TAB_STEP - tcon_pkg::COL_W'(1));
            end
            tcon_pkg::CH_CR:
            begin
                col_put = '0;
            end
            tcon_pkg::CH_LF:
            begin
                col_put = '0;
                row_put = row_reg + tcon_pkg::ROW_W'(1);
            end
            default:
            begin
                if (printable)
                begin
                    col_put = col_reg + tcon_pkg::COL_W'(1);
                end
            end
        endcase
        if (col_put >= tcon_pkg::COL_W'(tcon_pkg::COLUMNS))
        begin
            col_put = '0;
            row_put = row_put + tcon_pkg::ROW_W'(1);
        end
    end

    assign put_scroll = row_put >= tcon_pkg::ROW_W'(tcon_pkg::ROWS);

    always_comb
    begin
        ram_wr      = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = req_reg.cell_index;
        case (state_reg)
            ST_INIT, ST_SWEEP:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = cnt_reg;
                ram_wr.data = tcon_pkg::BLANK_CELL;
            end
            ST_EXEC:
            begin
                ram_wr.en   = (req_reg.action == tcon_pkg::ACT_PUT) && printable
                              && (put_pos < tcon_pkg::ADDR_W'(tcon_pkg::CELLS));
                ram_wr.addr = put_pos;
                ram_wr.data = {req_reg.bg_colour, req_reg.fg_colour, req_reg.char_code};
                ram_rd_en   = (req_reg.action == tcon_pkg::ACT_READ) && index_ok;
            end
            ST_SCROLL:
            begin
                ram_wr.en   = cnt_reg != '0;
                ram_wr.addr = cnt_m1;
                ram_wr.data = (cnt_m1 < COPY_CELLS) ? ram_rd_data : tcon_pkg::BLANK_CELL;
                ram_rd_en   = cnt_reg < COPY_CELLS;
                ram_rd_addr = cnt_reg + tcon_pkg::ADDR_W'(tcon_pkg::COLUMNS);
            end
            default:
            begin
                ram_wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            req_reg      <= '0;
            scrolled_reg <= 1'b0;
            word_ok_reg  <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_INIT:
                begin
                    cnt_reg <= cnt_reg + tcon_pkg::ADDR_W'(1);
                    if (cnt_reg == LAST_CELL)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= cmd;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    cnt_reg      <= '0;
                    scrolled_reg <= 1'b0;
                    word_ok_reg  <= (req_reg.action == tcon_pkg::ACT_READ) && index_ok;
                    state_reg    <= ST_DONE;
                    case (req_reg.action)
                        tcon_pkg::ACT_PUT:
                        begin
                            col_reg <= col_put;
                            if (put_scroll)
                            begin
                                row_reg      <= tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1);
                                scrolled_reg <= 1'b1;
                                state_reg    <= ST_SCROLL;
                            end
                            else
                            begin
                                row_reg <= row_put;
                            end
                        end
                        tcon_pkg::ACT_CLEAR:
                        begin
                            col_reg   <= '0;
                            row_reg   <= '0;
                            state_reg <= ST_SWEEP;
                        end
                        default:
                        begin
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_SWEEP:
                begin
                    cnt_reg <= cnt_reg + tcon_pkg::ADDR_W'(1);
                    if (cnt_reg == LAST_CELL)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCROLL:
                begin
                    cnt_reg <= cnt_reg + tcon_pkg::ADDR_W'(1);
                    if (cnt_reg == END_SCROLL)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    result_reg.cursor_column   <= col_reg;
                    result_reg.cursor_row      <= row_reg;
                    result_reg.cursor_location <= 11'(tcon_pkg::cell_addr(row_reg, col_reg));
                    result_reg.cell_word       <= word_ok_reg ? ram_rd_data : '0;
                    result_reg.scrolled        <= scrolled_reg;
                    done_reg                   <= 1'b1;
                    state_reg                  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (col_reg < tcon_pkg::COL_W'(tcon_pkg::COLUMNS))
                  && (row_reg < tcon_pkg::ROW_W'(tcon_pkg::ROWS)))
        else $error("cursor outside the screen while idle");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |-> ram_wr.addr < tcon_pkg::ADDR_W'(tcon_pkg::CELLS))
        else $error("store write beyond the last cell");

endmodule

`default_nettype wire
